// File: src/great_circle_distance_assert.svh
// Assertion macros for the great circle distance checker.
`ifndef GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GCD_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GCD_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: src/gcd_pkg.sv
// Shared types, constants and the CORDIC arctangent table.
`default_nettype none

package gcd_pkg;

    // Control bits that travel with each pipeline stage
    typedef struct packed {
        logic valid;
        logic zero;
    } pipe_ctl_t;

    // One full turn in degrees * 65536
    localparam logic [26:0] TURN_DEG_Q16 = 27'd23592960;

    // floor(w / 45) == (w * RECIP_45) >> RECIP_SHIFT for w below 2^26
    localparam logic [31:0] RECIP_45    = 32'd3054198967;
    localparam int          RECIP_SHIFT = 37;

    // CORDIC gain in Q30
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

    // Nautical miles * 256 per full turn
    localparam logic [22:0] NM_PER_TURN_Q8 = 23'd5529600;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [31:0] atan_ba(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10680862;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            5'd24:   val = 32'd41;
            5'd25:   val = 32'd20;
            5'd26:   val = 32'd10;
            5'd27:   val = 32'd5;
            5'd28:   val = 32'd3;
            5'd29:   val = 32'd1;
            5'd30:   val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: src/gcd_angle.sv
// Degrees * 65536 to a 32-bit binary angle, three register stages.
`default_nettype none

module gcd_angle (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire gcd_pkg::pipe_ctl_t ctl_in,
    input  wire logic [26:0]       u_in,
    output gcd_pkg::pipe_ctl_t     ctl_out,
    output logic [31:0]            ba_out
);

    localparam logic [26:0] T1 = gcd_pkg::TURN_DEG_Q16;
    localparam logic [26:0] T2 = 27'(2 * 23592960);
    localparam logic [26:0] T3 = 27'(3 * 23592960);

    gcd_pkg::pipe_ctl_t ctl1_reg, ctl2_reg, ctl3_reg;
    logic [24:0] ur_reg, ur_next;
    logic [58:0] prod_reg, prod_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] ba_reg, ba_next;
    logic [29:0] v;
    logic [26:0] w;

    // Stage 1: drop whole turns
    always_comb
    begin
        if (u_in >= T3)
            ur_next = 25'(u_in - T3);
        else if (u_in >= T2)
            ur_next = 25'(u_in - T2);
        else if (u_in >= T1)
            ur_next = 25'(u_in - T1);
        else
            ur_next = 25'(u_in);
    end

    // Stage 2: angle = 182*u + floor((16*u + 180) / 360)
    always_comb
    begin
        v         = {1'b0, ur_reg, 4'b0000} + 30'd180;
        w         = v[29:3];
        prod_next = 59'(w) * 59'(gcd_pkg::RECIP_45);
        base_next = 32'(33'(ur_reg) * 33'd182);
    end

    // Stage 3: final add
    assign ba_next = base_reg + 32'(prod_reg >> gcd_pkg::RECIP_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ur_reg   <= ur_next;
            prod_reg <= prod_next;
            base_reg <= base_next;
            ba_reg   <= ba_next;
        end
    end

    assign ctl_out = ctl3_reg;
    assign ba_out  = ba_reg;

endmodule

`default_nettype wire

// File: src/gcd_sincos.sv
// Pipelined CORDIC rotation: sine and cosine of a binary angle in Q30.
`default_nettype none

module gcd_sincos #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire gcd_pkg::pipe_ctl_t ctl_in,
    input  wire logic [31:0]        ba_in,
    output gcd_pkg::pipe_ctl_t      ctl_out,
    output logic signed [31:0]      s_out,
    output logic signed [31:0]      c_out
);

    localparam int Steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    gcd_pkg::pipe_ctl_t ctl_reg [0:Steps];
    logic signed [33:0] x_reg [0:Steps];
    logic signed [33:0] y_reg [0:Steps];
    logic signed [33:0] z_reg [0:Steps];
    logic               neg_reg [0:Steps];

    gcd_pkg::pipe_ctl_t ctlo_reg;
    logic signed [31:0] s_reg, s_next;
    logic signed [31:0] c_reg, c_next;

    logic [1:0]  quad;
    logic        neg_next;
    logic [31:0] ba_fold;

    // Fold quadrants two and three onto the right half plane
    always_comb
    begin
        quad     = ba_in[31:30];
        neg_next = (quad == 2'd1) || (quad == 2'd2);
        ba_fold  = neg_next ? (ba_in + 32'h8000_0000) : ba_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg[0] <= '0;
        else if (en)
            ctl_reg[0] <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= gcd_pkg::CORDIC_GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= {{2{ba_fold[31]}}, ba_fold};
            neg_reg[0] <= neg_next;
        end
    end

    // One rotation per stage
    for (genvar i = 0; i < Steps; i++)
    begin : g_iter
        localparam logic signed [33:0] Atan = 34'(gcd_pkg::atan_ba(5'(i)));
        logic signed [33:0] xs, ys;
        logic signed [33:0] x_next, y_next, z_next;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_comb
        begin
            if (!z_reg[i][33])
            begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - Atan;
            end
            else
            begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + Atan;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i+1] <= '0;
            else if (en)
                ctl_reg[i+1] <= ctl_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]   <= x_next;
                y_reg[i+1]   <= y_next;
                z_reg[i+1]   <= z_next;
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // Undo the fold
    always_comb
    begin
        s_next = neg_reg[Steps] ? 32'(-y_reg[Steps]) : 32'(y_reg[Steps]);
        c_next = neg_reg[Steps] ? 32'(-x_reg[Steps]) : 32'(x_reg[Steps]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctlo_reg <= '0;
        else if (en)
            ctlo_reg <= ctl_reg[Steps];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= s_next;
            c_reg <= c_next;
        end
    end

    assign ctl_out = ctlo_reg;
    assign s_out   = s_reg;
    assign c_out   = c_reg;

endmodule

`default_nettype wire

// File: src/gcd_cosine.sv
// Law of cosines sum, clamp, and 1 - c^2 for the square root, four stages.
`default_nettype none

module gcd_cosine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire gcd_pkg::pipe_ctl_t ctl_in,
    input  wire logic signed [31:0] sa_in,
    input  wire logic signed [31:0] ca_in,
    input  wire logic signed [31:0] sb_in,
    input  wire logic signed [31:0] cb_in,
    input  wire logic signed [31:0] cd_in,
    output gcd_pkg::pipe_ctl_t      ctl_out,
    output logic signed [31:0]      c_out,
    output logic [60:0]             r_out
);

    gcd_pkg::pipe_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;

    logic signed [63:0] ss_reg, ss_next;
    logic signed [63:0] cc_reg, cc_next;
    logic signed [31:0] cd_reg;
    logic signed [33:0] t1_reg, t1_next;
    logic signed [31:0] m;
    logic signed [63:0] pm_reg, pm_next;
    logic signed [34:0] sum;
    logic signed [31:0] c_reg, c_next;
    logic signed [31:0] c4_reg;
    logic signed [63:0] sq;
    logic [60:0]        r_reg, r_next;

    // Stage 1: products of the latitude terms
    always_comb
    begin
        ss_next = sa_in * sb_in;
        cc_next = ca_in * cb_in;
    end

    // Stage 2: scale back, times cos of longitude difference
    always_comb
    begin
        t1_next = 34'(ss_reg >>> 30);
        m       = 32'(cc_reg >>> 30);
        pm_next = m * cd_reg;
    end

    // Stage 3: sum and clamp to [-1, 1]
    always_comb
    begin
        sum = 35'(t1_reg) + 35'(pm_reg >>> 30);
        if (sum > 35'(gcd_pkg::ONE_Q30))
            c_next = 32'(gcd_pkg::ONE_Q30);
        else if (sum < -35'(gcd_pkg::ONE_Q30))
            c_next = 32'(-gcd_pkg::ONE_Q30);
        else
            c_next = 32'(sum);
    end

    // Stage 4: radicand 2^60 - c^2
    always_comb
    begin
        sq     = c_reg * c_reg;
        r_next = 61'(64'h1000_0000_0000_0000 - sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss_reg <= ss_next;
            cc_reg <= cc_next;
            cd_reg <= cd_in;
            t1_reg <= t1_next;
            pm_reg <= pm_next;
            c_reg  <= c_next;
            c4_reg <= c_reg;
            r_reg  <= r_next;
        end
    end

    assign ctl_out = ctl4_reg;
    assign c_out   = c4_reg;
    assign r_out   = r_reg;

endmodule

`default_nettype wire

// File: src/gcd_acos.sv
// Square root, CORDIC vectoring arc cosine and scaling to nautical miles.
`default_nettype none

module gcd_acos #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire gcd_pkg::pipe_ctl_t ctl_in,
    input  wire logic signed [31:0] c_in,
    input  wire logic [60:0]        r_in,
    output gcd_pkg::pipe_ctl_t      ctl_out,
    output logic [21:0]             range_out
);

    localparam int Steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    // radicand is at most 2^60: 31 two-bit digits
    localparam int SqSteps = 31;

    // square root stages
    gcd_pkg::pipe_ctl_t sctl_reg [1:SqSteps];
    logic [61:0]        rem_reg  [1:SqSteps];
    logic [61:0]        res_reg  [1:SqSteps];
    logic signed [31:0] cs_reg   [1:SqSteps];

    for (genvar j = 0; j < SqSteps; j++)
    begin : g_sqrt
        localparam logic [61:0] Bit = 62'(1) << (2 * (SqSteps - 1 - j));
        gcd_pkg::pipe_ctl_t ctl_cur;
        logic [61:0]        rem_cur, res_cur, trial;
        logic [61:0]        rem_next, res_next;
        logic signed [31:0] c_cur;

        if (j == 0)
        begin : g_first
            assign ctl_cur = ctl_in;
            assign rem_cur = 62'(r_in);
            assign res_cur = '0;
            assign c_cur   = c_in;
        end
        else
        begin : g_rest
            assign ctl_cur = sctl_reg[j];
            assign rem_cur = rem_reg[j];
            assign res_cur = res_reg[j];
            assign c_cur   = cs_reg[j];
        end

        always_comb
        begin
            trial = res_cur + Bit;
            if (rem_cur >= trial)
            begin
                rem_next = rem_cur - trial;
                res_next = (res_cur >> 1) + Bit;
            end
            else
            begin
                rem_next = rem_cur;
                res_next = res_cur >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sctl_reg[j+1] <= '0;
            else if (en)
                sctl_reg[j+1] <= ctl_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= rem_next;
                res_reg[j+1] <= res_next;
                cs_reg[j+1]  <= c_cur;
            end
        end
    end

    // Start of vectoring: point (c, sqrt(1 - c^2)), turned a quarter when c < 0
    gcd_pkg::pipe_ctl_t ctl_reg [0:Steps];
    logic signed [33:0] x_reg [0:Steps];
    logic signed [33:0] y_reg [0:Steps];
    logic signed [33:0] z_reg [0:Steps];
    logic signed [33:0] x0_next, y0_next, z0_next, root;

    always_comb
    begin
        root = 34'(res_reg[SqSteps][30:0]);
        if (cs_reg[SqSteps][31])
        begin
            x0_next = root;
            y0_next = -34'(cs_reg[SqSteps]);
            z0_next = gcd_pkg::QUARTER_TURN;
        end
        else
        begin
            x0_next = 34'(cs_reg[SqSteps]);
            y0_next = root;
            z0_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg[0] <= '0;
        else if (en)
            ctl_reg[0] <= sctl_reg[SqSteps];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            z_reg[0] <= z0_next;
        end
    end

    // One vectoring step per stage, driving y toward zero
    for (genvar i = 0; i < Steps; i++)
    begin : g_iter
        localparam logic signed [33:0] Atan = 34'(gcd_pkg::atan_ba(5'(i)));
        logic signed [33:0] xs, ys;
        logic signed [33:0] x_next, y_next, z_next;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_comb
        begin
            if (!y_reg[i][33] && (y_reg[i] != '0))
            begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + Atan;
            end
            else
            begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - Atan;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i+1] <= '0;
            else if (en)
                ctl_reg[i+1] <= ctl_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                z_reg[i+1] <= z_next;
            end
        end
    end

    // Clamp to half a turn and scale to nautical miles
    gcd_pkg::pipe_ctl_t ctlp_reg, ctlo_reg;
    logic [31:0] zc;
    logic [54:0] prod_reg, prod_next;
    logic [55:0] rounded;
    logic [21:0] range_reg, range_next;

    always_comb
    begin
        if (z_reg[Steps][33])
            zc = '0;
        else if (z_reg[Steps] > gcd_pkg::HALF_TURN)
            zc = 32'(gcd_pkg::HALF_TURN);
        else
            zc = z_reg[Steps][31:0];
        prod_next = 55'(zc) * 55'(gcd_pkg::NM_PER_TURN_Q8);
    end

    // Round half up; identical points give exactly zero
    always_comb
    begin
        rounded    = 56'(prod_reg) + 56'h80_0000_0000 / 56'd256;
        range_next = ctlp_reg.zero ? '0 : 22'(rounded >> 32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctlp_reg <= '0;
            ctlo_reg <= '0;
        end
        else if (en)
        begin
            ctlp_reg <= ctl_reg[Steps];
            ctlo_reg <= ctlp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            range_reg <= range_next;
        end
    end

    assign ctl_out   = ctlo_reg;
    assign range_out = range_reg;

endmodule

`default_nettype wire

// File: src/great_circle_distance.sv
// Great circle distance top level; throughput one transaction per cycle unless the output stalls.
// Every CORDIC and square root digit has its own stage.
// The whole pipeline advances together whenever the output register is empty or taken.
// rst_n clears all stage valid bits asynchronously; data registers are not reset.
`default_nettype none

module great_circle_distance #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,  // lat_a[23:0], lon_a[48:24], lat_b[72:49], lon_b[97:73], zero pad
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [23:0]       m_tdata   // range_nm[21:0], zero pad
);

    logic signed [23:0] lat_a, lat_b;
    logic signed [24:0] lon_a, lon_b;
    logic [26:0]        u_a, u_b, u_d;
    logic               en;

    gcd_pkg::pipe_ctl_t ctl_in, ctl_ang, ctl_sc, ctl_cos, ctl_out;
    logic [31:0]        ba_a, ba_b, ba_d;
    logic signed [31:0] sa, ca, sb, cb, cd;
    logic signed [31:0] c_val;
    logic [60:0]        radicand;
    logic [21:0]        range_nm;

    // Unpack the transaction
    always_comb
    begin
        lat_a = s_tdata[23:0];
        lon_a = s_tdata[48:24];
        lat_b = s_tdata[72:49];
        lon_b = s_tdata[97:73];
    end

    // Offsets make every operand positive before the turn reduction
    always_comb
    begin
        u_a = 27'(lat_a) + gcd_pkg::TURN_DEG_Q16;
        u_b = 27'(lat_b) + gcd_pkg::TURN_DEG_Q16;
        u_d = 27'(lon_a) - 27'(lon_b) + 27'(2 * 23592960);
        ctl_in.valid = s_tvalid;
        ctl_in.zero  = (lat_a == lat_b) && (lon_a == lon_b);
    end

    // Global advance
    assign en       = m_tready || !ctl_out.valid;
    assign s_tready = en;

    gcd_angle u_ang_a (
        .clk(clk), .rst_n(rst_n), .en(en),
        .ctl_in(ctl_in), .u_in(u_a), .ctl_out(ctl_ang), .ba_out(ba_a)
    );

    gcd_angle u_ang_b (
        .clk(clk), .rst_n(rst_n), .en(en),
        .ctl_in(ctl_in), .u_in(u_b), .ctl_out(), .ba_out(ba_b)
    );

    gcd_angle u_ang_d (
        .clk(clk), .rst_n(rst_n), .en(en),
        .ctl_in(ctl_in), .u_in(u_d), .ctl_out(), .ba_out(ba_d)
    );

    gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_a (
        .clk(clk), .rst_n(rst_n), .en(en),
        .ctl_in(ctl_ang), .ba_in(ba_a), .ctl_out(ctl_sc), .s_out(sa), .c_out(ca)
    );

    gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_b (
        .clk(clk), .rst_n(rst_n), .en(en),
        .ctl_in(ctl_ang), .ba_in(ba_b), .ctl_out(), .s_out(sb), .c_out(cb)
    );

    gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_d (
        .clk(clk), .rst_n(rst_n), .en(en),
        .ctl_in(ctl_ang), .ba_in(ba_d), .ctl_out(), .s_out(), .c_out(cd)
    );

    gcd_cosine u_cos (
        .clk(clk), .rst_n(rst_n), .en(en),
        .ctl_in(ctl_sc),
        .sa_in(sa), .ca_in(ca), .sb_in(sb), .cb_in(cb), .cd_in(cd),
        .ctl_out(ctl_cos), .c_out(c_val), .r_out(radicand)
    );

    gcd_acos #(.CORDIC_STEPS(CORDIC_STEPS)) u_acos (
        .clk(clk), .rst_n(rst_n), .en(en),
        .ctl_in(ctl_cos), .c_in(c_val), .r_in(radicand),
        .ctl_out(ctl_out), .range_out(range_nm)
    );

    assign m_tvalid = ctl_out.valid;
    assign m_tdata  = {2'b00, range_nm};

endmodule

`default_nettype wire

// File: src/gcd_checker.sv
// Port-level checks for great_circle_distance, bound to the top level.
`default_nettype none

`include "great_circle_distance_assert.svh"

module gcd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // A stalled result holds
    `GCD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Distance never passes half the circumference
    `GCD_ASSERT_IMP(a_range_max, m_tvalid, m_tdata[21:0] <= 22'd2764800, "range_nm above half a turn")

    // Pad bits stay zero
    `GCD_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[23:22] == 2'b00, "nonzero pad bits in m_tdata")

    // An empty output stage never blocks the input
    `GCD_ASSERT_IMP(a_ready_free, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

`default_nettype wire
